### src/xtea_pkg.sv
// Shared types, constants and the round function of the XTEA block cipher.
// Used by xtea_cell and xtea_block_cipher; depends on nothing else.
`default_nettype none

package xtea_pkg;

  localparam int unsigned CYCLES      = 32;
  localparam int unsigned HALF_ROUNDS = 2 * CYCLES;
  localparam int unsigned KEY_WORDS   = 4;
  localparam int unsigned KEY_IDX_W   = $clog2(KEY_WORDS);

  localparam logic [31:0] DELTA     = 32'h9E37_79B9;
  localparam logic [31:0] SUM_START = 32'h0000_0000;
  localparam logic [31:0] SUM_END   = 32'((64'(DELTA) * 64'(CYCLES)) & 64'hFFFF_FFFF);

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_t;

  typedef logic [KEY_WORDS-1:0][31:0] key_set_t;

  typedef struct packed {
    logic        valid;
    func_t       func;
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] sum;
  } slot_t;

  function automatic logic [31:0] mix(input logic [31:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage

`default_nettype wire

### src/xtea_block_cipher.sv
// Top level of the XTEA block cipher: key registers and a chain of half-round cells.
// Depends on xtea_pkg and xtea_cell.
`default_nettype none

// XTEA encryption and decryption of 64-bit blocks, one block per word, in ECB fashion.
// The 128-bit key is written as four 32-bit registers at indexes 0 to 3 and resets to zero;
// write it only while no block is in flight. The datapath is a chain of 64 half-round
// cells, two per cipher cycle, so a new block is accepted every clock while the output
// is not stalled; each result leaves the last cell, which also serves as the output register.
// When the output is stalled while it holds a result, the whole chain holds and the
// input is stalled in the same cycle.
module xtea_block_cipher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic        in_func,
  input  wire logic [31:0] in_word_first,
  input  wire logic [31:0] in_word_second,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [31:0] out_word_first_out,
  output      logic [31:0] out_word_second_out,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [xtea_pkg::KEY_IDX_W-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  xtea_pkg::key_set_t                     keys_r;
  xtea_pkg::slot_t                        chain [xtea_pkg::HALF_ROUNDS+1];
  logic [xtea_pkg::HALF_ROUNDS-1:0]       valid_vec;
  logic                                   advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      keys_r[cfg_index] <= cfg_data;
    end
  end

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  assign chain[0] = '{
    valid: in_valid,
    func:  xtea_pkg::func_t'(in_func),
    v0:    in_word_first,
    v1:    in_word_second,
    sum:   in_func ? xtea_pkg::SUM_END : xtea_pkg::SUM_START
  };

  for (genvar i = 0; i < xtea_pkg::HALF_ROUNDS; i++) begin : g_cell
    xtea_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .phase    (1'(i % 2)),
      .keys     (keys_r),
      .slot_in  (chain[i]),
      .slot_out (chain[i+1])
    );
    assign valid_vec[i] = chain[i+1].valid;
  end

  assign out_valid           = chain[xtea_pkg::HALF_ROUNDS].valid;
  assign out_word_first_out  = chain[xtea_pkg::HALF_ROUNDS].v0;
  assign out_word_second_out = chain[xtea_pkg::HALF_ROUNDS].v1;

`ifndef SYNTH
  a_first_cell_takes_word: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(advance) |-> valid_vec[0] == $past(in_valid))
    else $error("first cell did not take the input word");

  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(in_stall) |-> $stable(valid_vec))
    else $error("cell chain moved while stalled");

  a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> chain[xtea_pkg::HALF_ROUNDS].sum ==
      ((chain[xtea_pkg::HALF_ROUNDS].func == xtea_pkg::FUNC_DEC) ?
        xtea_pkg::SUM_START : xtea_pkg::SUM_END))
    else $error("result word left the chain with a wrong round sum");
`endif

endmodule

`default_nettype wire

### src/xtea_cell.sv
// One half-round cell of the XTEA chain: updates one half of the block and the round sum.
// Depends on xtea_pkg for the slot type, key set type and round function.
`default_nettype none

module xtea_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              phase,
  input  wire xtea_pkg::key_set_t keys,
  input  wire xtea_pkg::slot_t   slot_in,
  output xtea_pkg::slot_t        slot_out
);

  logic                           valid_r;
  xtea_pkg::func_t                func_r;
  logic [31:0]                    v0_r;
  logic [31:0]                    v1_r;
  logic [31:0]                    sum_r;

  logic                           dec;
  logic                           to_v0;
  logic [31:0]                    src;
  logic [xtea_pkg::KEY_IDX_W-1:0] kidx;
  logic [31:0]                    f;
  logic [31:0]                    dst;
  logic [31:0]                    dst_nxt;
  logic [31:0]                    v0_nxt;
  logic [31:0]                    v1_nxt;
  logic [31:0]                    sum_nxt;

  // The first half of an encryption round and the second half of a decryption round
  // both update v0 from v1 with the key picked by the low sum bits.
  always_comb begin
    dec   = (slot_in.func == xtea_pkg::FUNC_DEC);
    to_v0 = (dec == phase);
    src   = to_v0 ? slot_in.v1 : slot_in.v0;
    dst   = to_v0 ? slot_in.v0 : slot_in.v1;
    kidx  = to_v0 ? slot_in.sum[xtea_pkg::KEY_IDX_W-1:0]
                  : slot_in.sum[11 +: xtea_pkg::KEY_IDX_W];
    f       = xtea_pkg::mix(src) ^ (slot_in.sum + keys[kidx]);
    dst_nxt = dec ? (dst - f) : (dst + f);
    v0_nxt  = to_v0 ? dst_nxt : slot_in.v0;
    v1_nxt  = to_v0 ? slot_in.v1 : dst_nxt;
    if (phase) begin
      sum_nxt = slot_in.sum;
    end else if (dec) begin
      sum_nxt = slot_in.sum - xtea_pkg::DELTA;
    end else begin
      sum_nxt = slot_in.sum + xtea_pkg::DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= slot_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func_r <= slot_in.func;
      v0_r   <= v0_nxt;
      v1_r   <= v1_nxt;
      sum_r  <= sum_nxt;
    end
  end

  assign slot_out = '{valid: valid_r, func: func_r, v0: v0_r, v1: v1_r, sum: sum_r};

endmodule

`default_nettype wire
